@@ sv/next_prime_search_defines.svh @@
// Assertion macros shared by the next-prime search RTL.
// Needs clk_i and rst_ni in the scope of each use; ASSERT_OFF removes all checks.
`ifndef NEXT_PRIME_SEARCH_DEFINES_SVH
`define NEXT_PRIME_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
// Plain property, checked on every rising clock edge outside reset.
`define NPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication.
`define NPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define NPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NPS_ASSERT(lbl, prop, msg)
`define NPS_ASSERT_IMP(lbl, ante, cons, msg)
`define NPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/nps_pkg.sv @@
// Package for the next-prime search: field widths, microcode types and the control store.
// No dependencies; used by the channel interfaces and the top level.
package nps_pkg;

  // Payload widths of the channels.
  localparam int unsigned START_W = 16;
  localparam int unsigned PRIME_W = 16;

  // Microcode step address.
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned NUM_STEPS = 1 << STEP_W;
  typedef logic [STEP_W-1:0] step_t;

  // Step addresses of the program.
  localparam step_t ST_IDLE  = 4'd0;
  localparam step_t ST_CHKST = 4'd1;
  localparam step_t ST_INC   = 4'd2;
  localparam step_t ST_CHKC  = 4'd3;
  localparam step_t ST_CHK2  = 4'd4;
  localparam step_t ST_SQ    = 4'd5;
  localparam step_t ST_DIV   = 4'd6;
  localparam step_t ST_REM   = 4'd7;
  localparam step_t ST_PRIME = 4'd8;
  localparam step_t ST_OVF   = 4'd9;
  localparam step_t ST_FIN   = 4'd10;

  // Jump conditions selectable by a control word.
  typedef enum logic [3:0] {
    C_NONE,
    C_NOT_IN_VALID,
    C_START_OVF,
    C_CAND_OVER,
    C_CAND_LT2,
    C_SQ_GT,
    C_BIT_MORE,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_e;

  // Datapath strobes of one control word.
  typedef struct packed {
    logic in_rdy;
    logic ld_start;
    logic inc_cand;
    logic init_div;
    logic init_bit;
    logic div_step;
    logic next_div;
    logic set_prime;
    logic set_ovf;
    logic ld_out;
  } op_t;

  // One control word: jump to jmp when cond holds, else go to nxt.
  typedef struct packed {
    cond_e cond;
    step_t jmp;
    step_t nxt;
    op_t   ops;
  } ctrl_t;

  localparam op_t OP_NONE = '0;

  // The control store. Unused addresses fall back to idle.
  localparam ctrl_t UCODE [NUM_STEPS] = '{
    ST_IDLE:  '{cond: C_NOT_IN_VALID, jmp: ST_IDLE, nxt: ST_CHKST,
                ops: op_t'{in_rdy: 1'b1, ld_start: 1'b1, default: 1'b0}},
    ST_CHKST: '{cond: C_START_OVF, jmp: ST_OVF, nxt: ST_INC, ops: OP_NONE},
    ST_INC:   '{cond: C_NONE, jmp: ST_CHKC, nxt: ST_CHKC,
                ops: op_t'{inc_cand: 1'b1, default: 1'b0}},
    ST_CHKC:  '{cond: C_CAND_OVER, jmp: ST_OVF, nxt: ST_CHK2, ops: OP_NONE},
    ST_CHK2:  '{cond: C_CAND_LT2, jmp: ST_INC, nxt: ST_SQ,
                ops: op_t'{init_div: 1'b1, default: 1'b0}},
    ST_SQ:    '{cond: C_SQ_GT, jmp: ST_PRIME, nxt: ST_DIV,
                ops: op_t'{init_bit: 1'b1, default: 1'b0}},
    ST_DIV:   '{cond: C_BIT_MORE, jmp: ST_DIV, nxt: ST_REM,
                ops: op_t'{div_step: 1'b1, default: 1'b0}},
    ST_REM:   '{cond: C_REM_ZERO, jmp: ST_INC, nxt: ST_SQ,
                ops: op_t'{next_div: 1'b1, default: 1'b0}},
    ST_PRIME: '{cond: C_NONE, jmp: ST_FIN, nxt: ST_FIN,
                ops: op_t'{set_prime: 1'b1, default: 1'b0}},
    ST_OVF:   '{cond: C_NONE, jmp: ST_FIN, nxt: ST_FIN,
                ops: op_t'{set_ovf: 1'b1, default: 1'b0}},
    ST_FIN:   '{cond: C_OUT_BUSY, jmp: ST_FIN, nxt: ST_IDLE,
                ops: op_t'{ld_out: 1'b1, default: 1'b0}},
    default:  '{cond: C_NONE, jmp: ST_IDLE, nxt: ST_IDLE, ops: OP_NONE}
  };

endpackage

@@ sv/nps_if.sv @@
// Valid/ready channel interfaces for the start value and the search result.
// Depends on nps_pkg for the payload widths.

// Input channel: one start value per word.
interface nps_in_if import nps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

// Output channel: one prime and overflow flag per word.
interface nps_out_if import nps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRIME_W-1:0] next_prime;
  logic               overflow;

  modport source (output valid, output next_prime, output overflow, input ready);
  modport sink   (input valid, input next_prime, input overflow, output ready);
endinterface

@@ sv/next_prime_search.sv @@
// Next-prime search by trial division, run by a microcoded sequencer; one word at a time.
// Each tested candidate runs a trial-divisor loop; the divisor loop is a restoring remainder
// that takes one candidate bit per cycle. A new word is taken only at idle.
// Reset (asynchronous, active low) puts the step counter at idle, empties the output register
// and clears the datapath registers.
module next_prime_search import nps_pkg::*; #(
  parameter int unsigned WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nps_in_if.sink    in_i,
  nps_out_if.source out_o
);

  `include "next_prime_search_defines.svh"

  // Candidate holds one above the top value, divisors and squares get headroom.
  localparam int unsigned CW = WIDTH + 1;
  localparam int unsigned DW = WIDTH / 2 + 2;
  localparam int unsigned SW = WIDTH + 3;
  localparam int unsigned BW = $clog2(WIDTH);
  localparam logic [32:0] TOP = (33'd1 << WIDTH) - 33'd1;

  step_t             step_q, step_d;
  ctrl_t             ctrl;
  logic              jump;
  logic              out_busy;

  logic [CW-1:0]     cand_q, cand_d;
  logic [DW-1:0]     div_q, div_d;
  logic [SW-1:0]     sq_q, sq_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [BW-1:0]     bit_q, bit_d;
  logic              start_ovf_q, start_ovf_d;
  logic [WIDTH-1:0]  res_q, res_d;
  logic              res_ovf_q, res_ovf_d;
  logic              out_vld_q, out_vld_d;
  logic [PRIME_W-1:0] out_prime_q, out_prime_d;
  logic              out_ovf_q, out_ovf_d;

  logic [32:0]       start_ext;
  logic [31:0]       res_ext;
  logic [WIDTH-1:0]  cand_lo;
  logic [DW:0]       rem_sh;
  logic [DW:0]       rem_sub;

  // Fetch the control word of the current step.
  assign ctrl = UCODE[step_q];

  assign out_busy = out_vld_q && !out_o.ready;

  // Jump condition select.
  always_comb begin
    case (ctrl.cond)
      C_NONE:         jump = 1'b0;
      C_NOT_IN_VALID: jump = !in_i.valid;
      C_START_OVF:    jump = start_ovf_q;
      C_CAND_OVER:    jump = 33'(cand_q) > TOP;
      C_CAND_LT2:     jump = cand_q < CW'(2);
      C_SQ_GT:        jump = sq_q > SW'(cand_q);
      C_BIT_MORE:     jump = bit_q != '0;
      C_REM_ZERO:     jump = rem_q == '0;
      C_OUT_BUSY:     jump = out_busy;
      default:        jump = 1'b0;
    endcase
    step_d = jump ? ctrl.jmp : ctrl.nxt;
  end

  assign start_ext = 33'(in_i.start_value);
  assign cand_lo   = cand_q[WIDTH-1:0];
  assign res_ext   = 32'(res_q);

  // One restoring step of the remainder: shift in a candidate bit, subtract if it fits.
  assign rem_sh  = {rem_q, cand_lo[bit_q]};
  assign rem_sub = rem_sh - {1'b0, div_q};

  // Datapath driven by the strobes of the control word.
  always_comb begin
    cand_d      = cand_q;
    div_d       = div_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    start_ovf_d = start_ovf_q;
    res_d       = res_q;
    res_ovf_d   = res_ovf_q;
    out_vld_d   = out_vld_q;
    out_prime_d = out_prime_q;
    out_ovf_d   = out_ovf_q;

    if (ctrl.ops.ld_start && in_i.valid) begin
      cand_d      = start_ext[CW-1:0];
      start_ovf_d = start_ext >= TOP;
    end
    if (ctrl.ops.inc_cand) begin
      cand_d = cand_q + CW'(1);
    end
    if (ctrl.ops.init_div) begin
      div_d = DW'(2);
      sq_d  = SW'(4);
    end
    if (ctrl.ops.init_bit) begin
      rem_d = '0;
      bit_d = BW'(WIDTH - 1);
    end
    if (ctrl.ops.div_step) begin
      rem_d = (rem_sh >= {1'b0, div_q}) ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      bit_d = bit_q - BW'(1);
    end
    // (d + 1)^2 = d^2 + 2d + 1 keeps the square without a multiplier.
    if (ctrl.ops.next_div) begin
      div_d = div_q + DW'(1);
      sq_d  = sq_q + SW'({div_q, 1'b0}) + SW'(1);
    end
    if (ctrl.ops.set_prime) begin
      res_d     = cand_lo;
      res_ovf_d = 1'b0;
    end
    if (ctrl.ops.set_ovf) begin
      res_d     = '0;
      res_ovf_d = 1'b1;
    end

    // Output register: free when empty or being taken this cycle.
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (ctrl.ops.ld_out && !out_busy) begin
      out_vld_d   = 1'b1;
      out_prime_d = res_ext[PRIME_W-1:0];
      out_ovf_d   = res_ovf_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q      <= '0;
      div_q       <= '0;
      sq_q        <= '0;
      rem_q       <= '0;
      bit_q       <= '0;
      start_ovf_q <= 1'b0;
      res_q       <= '0;
      res_ovf_q   <= 1'b0;
      out_prime_q <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      cand_q      <= cand_d;
      div_q       <= div_d;
      sq_q        <= sq_d;
      rem_q       <= rem_d;
      bit_q       <= bit_d;
      start_ovf_q <= start_ovf_d;
      res_q       <= res_d;
      res_ovf_q   <= res_ovf_d;
      out_prime_q <= out_prime_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign in_i.ready       = ctrl.ops.in_rdy;
  assign out_o.valid      = out_vld_q;
  assign out_o.next_prime = out_prime_q;
  assign out_o.overflow   = out_ovf_q;

  // Checks on the sequencer and datapath.
  `NPS_ASSERT_IMP(a_ovf_zero, out_o.valid && out_o.overflow, out_o.next_prime == '0,
    "overflow word carries a nonzero prime")
  `NPS_ASSERT_IMP(a_rem_below_div, step_q == ST_DIV || step_q == ST_REM,
    div_q >= DW'(2) && rem_q < div_q, "remainder not below trial divisor")
  `NPS_ASSERT_IMP(a_prime_valid, step_q == ST_PRIME,
    !start_ovf_q && cand_q >= CW'(2) && 33'(cand_q) <= TOP, "prime taken from bad candidate")
  `NPS_ASSERT_NXT(a_accept_step, in_i.valid && in_i.ready, step_q == ST_CHKST,
    "accepted word did not start the search")

endmodule
